// File: hdl/swhsr_pkg.sv
// package: shared types and constants of the single-wire humidity sensor reader
package swhsr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int CNT_W      = 12;
  localparam int BIDX_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [11:0] START_LOW_RST = 12'd1800;
  localparam logic [7:0]  RELEASE_RST   = 8'd30;
  localparam logic [7:0]  TIMEOUT_RST   = 8'd100;
  localparam logic [7:0]  THRESHOLD_RST = 8'd40;

  // sign bit and magnitude mask of the raw temperature word
  localparam logic [15:0] TEMP_SIGN = 16'h8000;
  localparam logic [15:0] TEMP_MAG  = 16'h7FFF;

  // request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // transaction status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_t;

  // sequencer phases, one-hot
  typedef enum logic [10:0] {
    PH_IDLE  = 11'b000_0000_0001,
    PH_START = 11'b000_0000_0010,
    PH_REL   = 11'b000_0000_0100,
    PH_RLS   = 11'b000_0000_1000,
    PH_RLH   = 11'b000_0001_0000,
    PH_RHS   = 11'b000_0010_0000,
    PH_RHH   = 11'b000_0100_0000,
    PH_BLS   = 11'b000_1000_0000,
    PH_BLH   = 11'b001_0000_0000,
    PH_BHS   = 11'b010_0000_0000,
    PH_BHH   = 11'b100_0000_0000
  } phase_t;

  // input request payload
  typedef struct packed {
    logic kind;
    logic line_level;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } out_res_t;

endpackage

// File: hdl/single_wire_humidity_sensor_reader.sv
// top level: single-wire humidity/temperature sensor master sequencer
//
//  channel  ports                              payload
//  in       in_valid  in_ready  in_data        kind, line_level
//  out      out_valid out_ready out_data       drive_low .. temperature_tenths
//  cfg      cfg_we    cfg_index cfg_data       12-bit write, no read-back
//
// one request per cycle unless stalled: the sequencer state, the bit shifter and the
// checksum and sign conversion all settle combinationally from the state registers
// into the result register. every request gives one result, in the cycle after
// acceptance. a waiting result stalls input only when out_ready is low.
// synchronous active-low reset: sequencer idle, counters, frame and last values
// zero, registers at their defaults.
module single_wire_humidity_sensor_reader (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swhsr_pkg::in_req_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swhsr_pkg::out_res_t                 out_data,
  input  logic                                cfg_we,
  input  logic [swhsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swhsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [11:0] start_low_r;
  logic [7:0]  release_r;
  logic [7:0]  timeout_r;
  logic [7:0]  threshold_r;

  // sequencer state
  swhsr_pkg::phase_t                phase_r, phase_nxt;
  logic [swhsr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [swhsr_pkg::BIDX_W-1:0]     bidx_r, bidx_nxt;
  logic [swhsr_pkg::FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [15:0]                      hum_r, hum_nxt;
  logic [15:0]                      temp_r, temp_nxt;
  logic [1:0]                       stat_r, stat_nxt;
  logic                             done_nxt;

  // result register
  logic                 out_valid_r;
  swhsr_pkg::out_res_t  out_data_r;

  logic in_fire;

  // helpers
  logic [swhsr_pkg::CNT_W-1:0]      cnt_inc;
  logic [swhsr_pkg::CNT_W-1:0]      to_cnt;
  logic [swhsr_pkg::CNT_W-1:0]      bit_len;
  logic                             bit_val;
  logic [swhsr_pkg::FRAME_BITS-1:0] frame_sh;
  logic [swhsr_pkg::BIDX_W-1:0]     bidx_inc;
  logic [7:0]                       sum8;
  logic [15:0]                      raw_t;
  logic [15:0]                      temp_conv;
  logic                             cnt_over;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration writes, zero lengths act as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r <= swhsr_pkg::START_LOW_RST;
      release_r   <= swhsr_pkg::RELEASE_RST;
      timeout_r   <= swhsr_pkg::TIMEOUT_RST;
      threshold_r <= swhsr_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swhsr_pkg::REG_START_LOW: begin
          start_low_r <= (cfg_data == '0) ? 12'd1 : cfg_data[11:0];
        end
        swhsr_pkg::REG_RELEASE: begin
          release_r <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        end
        swhsr_pkg::REG_TIMEOUT: begin
          timeout_r <= cfg_data[7:0];
        end
        swhsr_pkg::REG_THRESHOLD: begin
          threshold_r <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // counter, timeout and bit decision
  assign cnt_inc  = cnt_r + 1'b1;
  assign to_cnt   = {4'd0, (timeout_r == 8'd0) ? 8'd1 : timeout_r};
  assign cnt_over = cnt_inc > to_cnt;
  assign bit_len  = in_data.line_level ? to_cnt : cnt_r;
  assign bit_val  = bit_len > {4'd0, threshold_r};
  assign frame_sh = {frame_r[swhsr_pkg::FRAME_BITS-2:0], bit_val};
  assign bidx_inc = bidx_r + 1'b1;

  // checksum and sign-magnitude conversion on the shifted frame
  assign sum8  = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];
  assign raw_t = frame_sh[23:8];
  assign temp_conv = ((raw_t & swhsr_pkg::TEMP_SIGN) != 16'd0)
                   ? 16'(16'd0 - (raw_t & swhsr_pkg::TEMP_MAG)) : raw_t;

  // sequencer next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bidx_nxt  = bidx_r;
    frame_nxt = frame_r;
    hum_nxt   = hum_r;
    temp_nxt  = temp_r;
    stat_nxt  = stat_r;
    done_nxt  = 1'b0;
    if (in_data.kind == swhsr_pkg::KIND_START) begin
      if (phase_r == swhsr_pkg::PH_IDLE) begin
        phase_nxt = swhsr_pkg::PH_START;
        cnt_nxt   = '0;
        bidx_nxt  = '0;
        frame_nxt = '0;
      end
    end else begin
      unique case (phase_r)
        swhsr_pkg::PH_IDLE: begin
        end
        swhsr_pkg::PH_START: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= start_low_r) begin
            phase_nxt = swhsr_pkg::PH_REL;
            cnt_nxt   = '0;
          end
        end
        swhsr_pkg::PH_REL: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= {4'd0, release_r}) begin
            phase_nxt = swhsr_pkg::PH_RLS;
            cnt_nxt   = '0;
          end
        end
        // seek phases: wait for the wanted level
        swhsr_pkg::PH_RLS, swhsr_pkg::PH_RHS, swhsr_pkg::PH_BLS, swhsr_pkg::PH_BHS: begin
          if (in_data.line_level == ((phase_r == swhsr_pkg::PH_RHS) ||
                                     (phase_r == swhsr_pkg::PH_BHS))) begin
            phase_nxt = swhsr_pkg::phase_t'({phase_r[9:0], 1'b0});
            cnt_nxt   = 12'd1;
          end else begin
            cnt_nxt = cnt_inc;
            if (cnt_over) begin
              phase_nxt = swhsr_pkg::PH_IDLE;
              cnt_nxt   = '0;
              stat_nxt  = swhsr_pkg::ST_TIMEOUT;
              done_nxt  = 1'b1;
            end
          end
        end
        // response and bit-low hold phases
        swhsr_pkg::PH_RLH, swhsr_pkg::PH_RHH, swhsr_pkg::PH_BLH: begin
          if (in_data.line_level == (phase_r == swhsr_pkg::PH_RHH)) begin
            cnt_nxt = cnt_inc;
            if (cnt_over) begin
              // clipped pulse, next wait starts on the next tick
              phase_nxt = (phase_r == swhsr_pkg::PH_RHH) ? swhsr_pkg::PH_BLS
                        : swhsr_pkg::phase_t'({phase_r[9:0], 1'b0});
              cnt_nxt   = '0;
            end
          end else begin
            // level changed, this sample opens the next pulse
            phase_nxt = (phase_r == swhsr_pkg::PH_RHH) ? swhsr_pkg::PH_BLH
                      : swhsr_pkg::phase_t'({phase_r[8:0], 2'b00});
            cnt_nxt   = 12'd1;
          end
        end
        // bit-high hold: measure, shift in the bit, maybe close the frame
        swhsr_pkg::PH_BHH: begin
          if (in_data.line_level && !cnt_over) begin
            cnt_nxt = cnt_inc;
          end else begin
            frame_nxt = frame_sh;
            bidx_nxt  = bidx_inc;
            if (bidx_inc >= swhsr_pkg::BIDX_W'(swhsr_pkg::FRAME_BITS)) begin
              phase_nxt = swhsr_pkg::PH_IDLE;
              cnt_nxt   = '0;
              done_nxt  = 1'b1;
              if (sum8 != frame_sh[7:0]) begin
                stat_nxt = swhsr_pkg::ST_CHECKSUM;
              end else begin
                stat_nxt = swhsr_pkg::ST_OK;
                hum_nxt  = frame_sh[39:24];
                temp_nxt = temp_conv;
              end
            end else if (in_data.line_level) begin
              phase_nxt = swhsr_pkg::PH_BLS;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = swhsr_pkg::PH_BLH;
              cnt_nxt   = 12'd1;
            end
          end
        end
        default: begin
          phase_nxt = swhsr_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  // state registers, updated on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swhsr_pkg::PH_IDLE;
      cnt_r   <= '0;
      bidx_r  <= '0;
      frame_r <= '0;
      hum_r   <= '0;
      temp_r  <= '0;
      stat_r  <= swhsr_pkg::ST_OK;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bidx_r  <= bidx_nxt;
      frame_r <= frame_nxt;
      hum_r   <= hum_nxt;
      temp_r  <= temp_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.drive_low          <= (phase_nxt == swhsr_pkg::PH_START);
      out_data_r.busy_res           <= (phase_nxt != swhsr_pkg::PH_IDLE);
      out_data_r.done_res           <= done_nxt;
      out_data_r.status             <= stat_nxt;
      out_data_r.humidity_tenths    <= hum_nxt;
      out_data_r.temperature_tenths <= temp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a start request taken while idle enters the start phase
  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.kind == swhsr_pkg::KIND_START && phase_r == swhsr_pkg::PH_IDLE)
    |=> (phase_r == swhsr_pkg::PH_START && out_valid_r && out_data_r.drive_low))
    else $error("start request did not enter start phase");

  // a finished transaction is never reported busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("done reported while busy");

  // driving the line low only while busy
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.drive_low) |-> out_data_r.busy_res)
    else $error("line driven low while idle");

  // the bit index never passes the frame length
  a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bidx_r <= swhsr_pkg::BIDX_W'(swhsr_pkg::FRAME_BITS))
    else $error("bit index beyond frame length");

endmodule
